@@ hdl/hfr_pkg.sv @@
// shared types, codes and hex decode for the hex frame receiver
package hfr_pkg;

  // input action selector codes
  localparam logic [1:0] ACT_CHAR = 2'd0;
  localparam logic [1:0] ACT_WAIT = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_TYPE     = 3'd0;
  localparam logic [2:0] KIND_BYTE     = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_REJECT   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

  // ack outcome on frame complete
  localparam logic [1:0] ACK_NONE     = 2'd0;
  localparam logic [1:0] ACK_RECEIVED = 2'd1;
  localparam logic [1:0] ACK_STRAY    = 2'd2;
  localparam logic [1:0] ACK_NON_ACK  = 2'd3;

  // reject reasons
  localparam logic [15:0] REJ_LENGTH = 16'd0;
  localparam logic [15:0] REJ_END    = 16'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_SYMBOL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT   = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_WAIT = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [3:0]  nib;
    logic [15:0] sent_type;
  } qent_t;

  typedef struct packed {
    logic [7:0]  start_symbol;
    logic [7:0]  end_symbol;
    logic [15:0] max_frame_bytes;
    logic [15:0] ack_type;
    logic [31:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic [1:0]  ack_status;
    logic [15:0] waited_type;
    logic        frame_last;
  } res_t;

  // no validity check, digits above '9' are taken as letters
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    begin
      if (c <= 8'h39) d = c - 8'h30;
      else            d = c - 8'h41 + 8'd10;
      return d[3:0];
    end
  endfunction

endpackage

@@ hdl/hfr_front.sv @@
// front end: classifies incoming items and decodes hex digits
module hfr_front (
  input  logic [1:0]          action,
  input  logic [7:0]          rx_char,
  input  logic [15:0]         sent_type,
  output logic                keep,
  output hfr_pkg::qent_t      ent
);
  import hfr_pkg::*;

  always_comb begin
    keep          = 1'b1;
    ent.op        = OP_CHAR;
    ent.ch        = rx_char;
    ent.nib       = hex_nibble(rx_char);
    ent.sent_type = sent_type;
    case (action)
      ACT_CHAR: ent.op = OP_CHAR;
      ACT_WAIT: ent.op = OP_WAIT;
      ACT_TICK: ent.op = OP_TICK;
      default:  keep   = 1'b0;  // unused action code is dropped here
    endcase
  end

endmodule

@@ hdl/hfr_queue.sv @@
// short queue between the front end and the frame engine
module hfr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hfr_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output hfr_pkg::qent_t head_ent
);
  import hfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  qent_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_ent   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_ent;
  end

endmodule

@@ hdl/hfr_back.sv @@
// frame engine: frame state machine, ack wait timer and output register
module hfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hfr_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  hfr_pkg::qent_t q_ent,
  output logic           q_pop,
  output logic           res_valid,
  output hfr_pkg::res_t  res,
  input  logic           res_ready
);
  import hfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [16:0] chars_left_r, chars_left_nxt;
  logic [15:0] length_accum_r, length_accum_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        nibble_phase_r, nibble_phase_nxt;
  logic [15:0] bytes_decoded_r, bytes_decoded_nxt;
  logic [15:0] frame_type_r, frame_type_nxt;
  logic        ack_waiting_r, ack_waiting_nxt;
  logic [15:0] awaited_type_r, awaited_type_nxt;
  logic [31:0] ack_elapsed_r, ack_elapsed_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r, out_res_nxt;

  logic        emit;
  res_t        emit_res;
  logic [15:0] len_shift;
  logic [7:0]  byte_val;
  logic [15:0] bytes_inc;
  logic [31:0] elapsed_inc;
  logic [16:0] chars_dec;

  // an item is taken whenever the output register is free or draining
  assign q_pop     = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  assign len_shift   = {length_accum_r[11:0], q_ent.nib};
  assign byte_val    = {high_nibble_r, q_ent.nib};
  assign bytes_inc   = bytes_decoded_r + 16'd1;
  assign elapsed_inc = ack_elapsed_r + 32'd1;
  assign chars_dec   = chars_left_r - 17'd1;

  always_comb begin
    phase_nxt         = phase_r;
    chars_left_nxt    = chars_left_r;
    length_accum_nxt  = length_accum_r;
    high_nibble_nxt   = high_nibble_r;
    nibble_phase_nxt  = nibble_phase_r;
    bytes_decoded_nxt = bytes_decoded_r;
    frame_type_nxt    = frame_type_r;
    ack_waiting_nxt   = ack_waiting_r;
    awaited_type_nxt  = awaited_type_r;
    ack_elapsed_nxt   = ack_elapsed_r;
    emit              = 1'b0;
    emit_res          = '0;

    if (q_pop) begin
      case (q_ent.op)
        OP_WAIT: begin
          ack_waiting_nxt  = 1'b1;
          awaited_type_nxt = q_ent.sent_type;
          ack_elapsed_nxt  = '0;
        end
        OP_TICK: begin
          if (ack_waiting_r) begin
            ack_elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= cfg.ack_timeout_ticks) begin
              emit                 = 1'b1;
              emit_res.kind        = KIND_TIMEOUT;
              emit_res.waited_type = awaited_type_r;
              ack_waiting_nxt      = 1'b0;
              awaited_type_nxt     = '0;
              ack_elapsed_nxt      = '0;
            end
          end
        end
        OP_CHAR: begin
          case (phase_r)
            PH_START: begin
              if (q_ent.ch == cfg.start_symbol) begin
                phase_nxt        = PH_LEN;
                chars_left_nxt   = 17'd4;
                length_accum_nxt = '0;
              end
            end
            PH_LEN: begin
              length_accum_nxt = len_shift;
              chars_left_nxt   = chars_dec;
              if (chars_dec == '0) begin
                if (len_shift == '0 || len_shift > cfg.max_frame_bytes) begin
                  phase_nxt           = PH_START;
                  emit                = 1'b1;
                  emit_res.kind       = KIND_REJECT;
                  emit_res.value      = REJ_LENGTH;
                  emit_res.frame_last = 1'b1;
                end else begin
                  phase_nxt         = PH_DATA;
                  chars_left_nxt    = {len_shift, 1'b0};
                  nibble_phase_nxt  = 1'b0;
                  high_nibble_nxt   = '0;
                  bytes_decoded_nxt = '0;
                  frame_type_nxt    = '0;
                end
              end
            end
            PH_DATA: begin
              chars_left_nxt = chars_dec;
              if (chars_dec == '0) phase_nxt = PH_END;
              if (!nibble_phase_r) begin
                high_nibble_nxt  = q_ent.nib;
                nibble_phase_nxt = 1'b1;
              end else begin
                nibble_phase_nxt  = 1'b0;
                bytes_decoded_nxt = bytes_inc;
                if (bytes_inc == 16'd1) begin
                  frame_type_nxt = {byte_val, 8'h00};
                  // one-byte frame: the type goes out with a zero low half
                  if (length_accum_r == 16'd1) begin
                    emit           = 1'b1;
                    emit_res.kind  = KIND_TYPE;
                    emit_res.value = {byte_val, 8'h00};
                  end
                end else if (bytes_inc == 16'd2) begin
                  frame_type_nxt = {frame_type_r[15:8], byte_val};
                  emit           = 1'b1;
                  emit_res.kind  = KIND_TYPE;
                  emit_res.value = {frame_type_r[15:8], byte_val};
                end else begin
                  emit           = 1'b1;
                  emit_res.kind  = KIND_BYTE;
                  emit_res.value = {8'h00, byte_val};
                end
              end
            end
            PH_END: begin
              phase_nxt           = PH_START;
              emit                = 1'b1;
              emit_res.frame_last = 1'b1;
              if (q_ent.ch != cfg.end_symbol) begin
                emit_res.kind  = KIND_REJECT;
                emit_res.value = REJ_END;
              end else begin
                emit_res.kind  = KIND_COMPLETE;
                emit_res.value = length_accum_r;
                if (ack_waiting_r) begin
                  emit_res.ack_status  = (frame_type_r == cfg.ack_type) ?
                                         ACK_RECEIVED : ACK_NON_ACK;
                  emit_res.waited_type = awaited_type_r;
                  ack_waiting_nxt      = 1'b0;
                  awaited_type_nxt     = '0;
                  ack_elapsed_nxt      = '0;
                end else if (frame_type_r == cfg.ack_type) begin
                  emit_res.ack_status = ACK_STRAY;
                end
              end
            end
            default: phase_nxt = PH_START;
          endcase
        end
        default: ;
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      chars_left_r    <= '0;
      length_accum_r  <= '0;
      high_nibble_r   <= '0;
      nibble_phase_r  <= 1'b0;
      bytes_decoded_r <= '0;
      frame_type_r    <= '0;
      ack_waiting_r   <= 1'b0;
      awaited_type_r  <= '0;
      ack_elapsed_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      chars_left_r    <= chars_left_nxt;
      length_accum_r  <= length_accum_nxt;
      high_nibble_r   <= high_nibble_nxt;
      nibble_phase_r  <= nibble_phase_nxt;
      bytes_decoded_r <= bytes_decoded_nxt;
      frame_type_r    <= frame_type_nxt;
      ack_waiting_r   <= ack_waiting_nxt;
      awaited_type_r  <= awaited_type_nxt;
      ack_elapsed_r   <= ack_elapsed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.frame_last |->
      out_res_r.kind == KIND_COMPLETE || out_res_r.kind == KIND_REJECT)
    else $error("frame_last on a result that does not end a frame");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ack_waiting_r |-> awaited_type_r == '0 && ack_elapsed_r == '0)
    else $error("wait state left over after the wait ended");

  a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEN |-> chars_left_r != '0 && chars_left_r <= 17'd4)
    else $error("length character count out of range");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_ready |=> !q_pop || !$past(q_pop))
    else $error("item taken while result register blocked");

  a_emit_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> q_pop)
    else $error("result produced without an item");

endmodule

@@ hdl/hex_frame_receiver_with_ack_wait.sv @@
// top level: configuration registers, front end, queue and frame engine
//
// hex frame receiver with ack wait
// in_* : one item per transfer; in_tuser selects a received character, a
//   start-of-ack-wait request or a timer tick. in_tdata carries the character
//   and the type of the packet just sent.
// out_*: at most one result per item; out_tuser gives the result kind and
//   out_tlast marks the result that completes or rejects a frame. payload
//   bytes of a frame that is later rejected are still delivered.
// cfg_*: register writes by index, always ready; write only while idle.
// result path: the queue is written at the item's transfer, then the frame
//   engine step pops the item and loads the output register.
// throughput: one item per cycle while the output is not stalled, set by the
//   frame engine step and the output register that takes a new result while one drains.
// a stalled output holds its result; the engine then stops popping and the
//   queue of QUEUE_DEPTH entries fills before in_tready drops.
// reset: registers return to their defaults, the frame engine waits for a
//   start symbol with no ack wait pending, and the queue empties.
module hex_frame_receiver_with_ack_wait #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hfr_pkg::IN_TDATA_W-1:0]    in_tdata,   // rx_char, sent_type
  input  logic [1:0]                        in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hfr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // value, ack_status, waited_type, zero fill
  output logic [2:0]                        out_tuser,  // kind
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hfr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  keep, q_full, q_valid, q_pop, res_valid;
  qent_t front_ent, head_ent;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_START_SYMBOL: cfg_nxt.start_symbol      = cfg_data[7:0];
        REG_END_SYMBOL:   cfg_nxt.end_symbol        = cfg_data[7:0];
        REG_MAX_BYTES:    cfg_nxt.max_frame_bytes   = cfg_data[15:0];
        REG_ACK_TYPE:     cfg_nxt.ack_type          = cfg_data[15:0];
        REG_ACK_TIMEOUT:  cfg_nxt.ack_timeout_ticks = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_symbol      <= 8'd2;
      cfg_r.end_symbol        <= 8'd3;
      cfg_r.max_frame_bytes   <= 16'd256;
      cfg_r.ack_type          <= 16'd0;
      cfg_r.ack_timeout_ticks <= 32'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !q_full;

  hfr_front u_front (
    .action    (in_tuser),
    .rx_char   (in_tdata[7:0]),
    .sent_type (in_tdata[23:8]),
    .keep      (keep),
    .ent       (front_ent)
  );

  hfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid && keep),
    .push_ent   (front_ent),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_ent   (head_ent)
  );

  hfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ent     (head_ent),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.kind;
  assign out_tlast  = res.frame_last;
  assign out_tdata  = {6'd0, res.waited_type, res.ack_status, res.value};

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the hex frame receiver with ack wait
module tb_top;
  import hfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int          PHASE_ITEMS   = 150;
  // action code the block ignores
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  ch;
    logic [15:0] st;
    logic        fixed;
    logic        has_res;
    res_t        res;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // rx_char, sent_type
  logic [1:0]             in_tuser   = '0;   // action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // value, ack_status, waited_type, zero fill
  logic [2:0]             out_tuser;         // kind
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles = 0;
  int          errors = 0;
  int          n_items = 0;
  int          n_checked = 0;
  int          kind_cnt[8];

  // receiver prediction state
  cfg_t        rx_cfg;
  phase_t      rx_phase;
  logic [16:0] chars_left;
  logic [15:0] len_acc;
  logic [3:0]  hi_nib;
  logic        nib_odd;
  logic [15:0] bytes_seen;
  logic [15:0] frame_type;
  logic        ack_pending;
  logic [15:0] awaited_type;
  logic [31:0] ticks_waited;

  res_t        pending_results[$];
  res_t        want;

  hex_frame_receiver_with_ack_wait dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = (c <= 8'h39) ? c - 8'h30 : c - 8'h41 + 8'd10;
    return v[3:0];
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [15:0] value,
                                  input logic [1:0] status, input logic [15:0] waited,
                                  input logic last);
    res_t r;
    r.kind        = kind;
    r.value       = value;
    r.ack_status  = status;
    r.waited_type = waited;
    r.frame_last  = last;
    return r;
  endfunction

  function automatic void end_ack_wait();
    ack_pending  = 1'b0;
    awaited_type = '0;
    ticks_waited = '0;
  endfunction

  function automatic bit take_rx_char(input logic [7:0] c, output res_t r);
    logic [3:0]  nib;
    logic [7:0]  dbyte;
    logic [1:0]  status;
    logic [15:0] waited;
    r = '0;
    case (rx_phase)
      PH_START: begin
        if (c == rx_cfg.start_symbol) begin
          rx_phase   = PH_LEN;
          chars_left = 17'd4;
          len_acc    = '0;
        end
        return 1'b0;
      end
      PH_LEN: begin
        len_acc    = {len_acc[11:0], nibble_of(c)};
        chars_left = chars_left - 17'd1;
        if (chars_left != '0) return 1'b0;
        if (len_acc == '0 || len_acc > rx_cfg.max_frame_bytes) begin
          rx_phase = PH_START;
          r = mk_res(KIND_REJECT, REJ_LENGTH, ACK_NONE, 16'h0, 1'b1);
          return 1'b1;
        end
        rx_phase   = PH_DATA;
        chars_left = {len_acc, 1'b0};
        nib_odd    = 1'b0;
        hi_nib     = '0;
        bytes_seen = '0;
        frame_type = '0;
        return 1'b0;
      end
      PH_DATA: begin
        nib        = nibble_of(c);
        chars_left = chars_left - 17'd1;
        if (chars_left == '0) rx_phase = PH_END;
        if (!nib_odd) begin
          hi_nib  = nib;
          nib_odd = 1'b1;
          return 1'b0;
        end
        nib_odd    = 1'b0;
        dbyte      = {hi_nib, nib};
        bytes_seen = bytes_seen + 16'd1;
        if (bytes_seen == 16'd1) begin
          // one-byte frame reports its type right away, low half zero
          frame_type = {dbyte, 8'h00};
          if (len_acc != 16'd1) return 1'b0;
          r = mk_res(KIND_TYPE, frame_type, ACK_NONE, 16'h0, 1'b0);
          return 1'b1;
        end
        if (bytes_seen == 16'd2) begin
          frame_type[7:0] = dbyte;
          r = mk_res(KIND_TYPE, frame_type, ACK_NONE, 16'h0, 1'b0);
          return 1'b1;
        end
        r = mk_res(KIND_BYTE, {8'h00, dbyte}, ACK_NONE, 16'h0, 1'b0);
        return 1'b1;
      end
      default: begin
        rx_phase = PH_START;
        if (c != rx_cfg.end_symbol) begin
          r = mk_res(KIND_REJECT, REJ_END, ACK_NONE, 16'h0, 1'b1);
          return 1'b1;
        end
        status = ACK_NONE;
        waited = '0;
        if (frame_type == rx_cfg.ack_type) begin
          if (ack_pending) begin
            status = ACK_RECEIVED;
            waited = awaited_type;
            end_ack_wait();
          end else begin
            status = ACK_STRAY;
          end
        end else if (ack_pending) begin
          status = ACK_NON_ACK;
          waited = awaited_type;
          end_ack_wait();
        end
        r = mk_res(KIND_COMPLETE, len_acc, status, waited, 1'b1);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit step_receiver(input logic [1:0] act, input logic [7:0] ch,
                                       input logic [15:0] st, output res_t r);
    r = '0;
    case (act)
      ACT_CHAR: return take_rx_char(ch, r);
      ACT_WAIT: begin
        // a new request overwrites the awaited type and restarts the count
        ack_pending  = 1'b1;
        awaited_type = st;
        ticks_waited = '0;
        return 1'b0;
      end
      ACT_TICK: begin
        if (!ack_pending) return 1'b0;
        ticks_waited = ticks_waited + 32'd1;
        if (ticks_waited < rx_cfg.ack_timeout_ticks) return 1'b0;
        r = mk_res(KIND_TIMEOUT, 16'h0, ACK_NONE, awaited_type, 1'b0);
        end_ack_wait();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $error("result with nothing pending: kind %0d value %0h", out_tuser, out_tdata[15:0]);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        kind_cnt[want.kind]++;
        if (out_tuser !== want.kind) begin
          errors++;
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
        end
        if (out_tdata[15:0] !== want.value) begin
          errors++;
          $error("value: expected %0h, got %0h", want.value, out_tdata[15:0]);
        end
        if (out_tdata[17:16] !== want.ack_status) begin
          errors++;
          $error("ack_status: expected %0d, got %0d", want.ack_status, out_tdata[17:16]);
        end
        if (out_tdata[33:18] !== want.waited_type) begin
          errors++;
          $error("waited_type: expected %0h, got %0h", want.waited_type, out_tdata[33:18]);
        end
        if (out_tlast !== want.frame_last) begin
          errors++;
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_tlast);
        end
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  function automatic stim_row_t row(input logic [1:0] act, input logic [7:0] ch,
                                    input logic [15:0] st, input logic fixed,
                                    input logic has_res, input res_t res);
    stim_row_t s;
    s.act     = act;
    s.ch      = ch;
    s.st      = st;
    s.fixed   = fixed;
    s.has_res = has_res;
    s.res     = res;
    return s;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    // upper and lower case letters decode alike
    if ($urandom_range(1) == 0) return 8'h37 + {4'h0, n};
    return 8'h57 + {4'h0, n};
  endfunction

  // one transfer on the input side; a fixed row overrides the prediction
  task automatic send_item(input logic [1:0] act, input logic [7:0] ch, input logic [15:0] st,
                           input logic fixed, input logic has_res, input res_t fixed_res);
    res_t r;
    bit   got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {st, ch};
    do @(posedge clk); while (!in_tready);
    got = step_receiver(act, ch, st, r);
    if (fixed) begin
      got = has_res;
      r   = fixed_res;
    end
    if (got) pending_results.push_back(r);
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    int pick;
    // ticks and wait requests may fall between the characters of a frame
    if ($urandom_range(99) < 6) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_item(ACT_TICK, 8'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
      else if (pick < 85)
        send_item(ACT_WAIT, 8'($urandom),
                  $urandom_range(1) ? rx_cfg.ack_type : 16'($urandom), 1'b0, 1'b0, '0);
      else
        send_item(ACT_UNUSED, 8'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
    end
    send_item(ACT_CHAR, c, 16'($urandom), 1'b0, 1'b0, '0);
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [15:0] ftype,
                            input logic good_end);
    logic [7:0] val;
    send_char(rx_cfg.start_symbol);
    for (int i = 3; i >= 0; i--) send_char(hex_char(len[4*i +: 4]));
    if (len == '0 || len > rx_cfg.max_frame_bytes) return;
    for (int b = 0; b < len; b++) begin
      if (b == 0)      val = ftype[15:8];
      else if (b == 1) val = ftype[7:0];
      else             val = 8'($urandom);
      if (b < 2 || $urandom_range(1) == 1) begin
        send_char(hex_char(val[7:4]));
        send_char(hex_char(val[3:0]));
      end else begin
        // any character decodes to some nibble
        send_char(8'($urandom));
        send_char(8'($urandom));
      end
    end
    send_char(good_end ? rx_cfg.end_symbol : 8'($urandom));
  endtask

  task automatic random_traffic(input int n);
    int          stop;
    int          pick;
    int          top;
    logic [15:0] len;
    logic [15:0] ftype;
    stop = n_items + n;
    while (n_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(2'($urandom), 8'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
      end else if (pick < 22) begin
        repeat ($urandom_range(1, 6))
          send_item(ACT_TICK, 8'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
      end else if (pick < 32) begin
        send_item(ACT_WAIT, 8'($urandom),
                  $urandom_range(1) ? rx_cfg.ack_type : 16'($urandom), 1'b0, 1'b0, '0);
      end else begin
        top = (rx_cfg.max_frame_bytes < 16'd8) ? int'(rx_cfg.max_frame_bytes) : 8;
        if ($urandom_range(99) < 8)
          len = (rx_cfg.max_frame_bytes == 16'hFFFF || $urandom_range(1) == 1) ?
                16'h0 : rx_cfg.max_frame_bytes + 16'd1;
        else
          len = 16'($urandom_range(1, top));
        ftype = ($urandom_range(99) < 40) ? rx_cfg.ack_type : 16'($urandom);
        send_frame(len, ftype, $urandom_range(99) < 90);
      end
    end
  endtask

  // hold the input side until every pending result is out and the queue settles
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_SYMBOL: rx_cfg.start_symbol      = value[7:0];
      REG_END_SYMBOL:   rx_cfg.end_symbol        = value[7:0];
      REG_MAX_BYTES:    rx_cfg.max_frame_bytes   = value[15:0];
      REG_ACK_TYPE:     rx_cfg.ack_type          = value[15:0];
      REG_ACK_TIMEOUT:  rx_cfg.ack_timeout_ticks = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper bits of the narrow registers carry noise
  task automatic set_regs(input logic [7:0] start_sym, input logic [7:0] end_sym,
                          input logic [15:0] max_bytes, input logic [15:0] ack,
                          input logic [31:0] timeout);
    write_reg(REG_START_SYMBOL, {24'($urandom), start_sym});
    write_reg(REG_END_SYMBOL,   {24'($urandom), end_sym});
    write_reg(REG_MAX_BYTES,    {16'($urandom), max_bytes});
    write_reg(REG_ACK_TYPE,     {16'($urandom), ack});
    write_reg(REG_ACK_TIMEOUT,  timeout);
  endtask

  initial begin
    stim_row_t dir_tab[$];

    rx_cfg.start_symbol      = 8'h02;
    rx_cfg.end_symbol        = 8'h03;
    rx_cfg.max_frame_bytes   = 16'd256;
    rx_cfg.ack_type          = 16'h0000;
    rx_cfg.ack_timeout_ticks = 32'd500;
    rx_phase   = PH_START;
    chars_left = '0;
    len_acc    = '0;
    hi_nib     = '0;
    nib_odd    = 1'b0;
    bytes_seen = '0;
    frame_type = '0;
    end_ack_wait();

    // ignored items, then a restarted wait and a zero-length frame
    dir_tab.push_back(row(ACT_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   8'h00, 16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_WAIT,   8'h00, 16'hFFFF, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_WAIT,   8'hFF, 16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   8'h02, 16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR,   "0",   16'h0000, 1'b1, 1'b1,
                          mk_res(KIND_REJECT, REJ_LENGTH, ACK_NONE, 16'h0, 1'b1)));
    // one-byte frame with a character outside the hex set, ends the wait
    dir_tab.push_back(row(ACT_CHAR, 8'h02, 16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "1",   16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, 8'hFF, 16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, 8'h03, 16'h0000, 1'b0, 1'b0, '0));
    // one-byte frame closed by a wrong end character
    dir_tab.push_back(row(ACT_CHAR, 8'h02, 16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "1",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b1, 1'b0, '0));
    dir_tab.push_back(row(ACT_CHAR, "0",   16'h0000, 1'b1, 1'b1,
                          mk_res(KIND_TYPE, 16'h0000, ACK_NONE, 16'h0, 1'b0)));
    dir_tab.push_back(row(ACT_CHAR, "Z",   16'h0000, 1'b1, 1'b1,
                          mk_res(KIND_REJECT, REJ_END, ACK_NONE, 16'h0, 1'b1)));

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_item(dir_tab[i].act, dir_tab[i].ch, dir_tab[i].st,
                dir_tab[i].fixed, dir_tab[i].has_res, dir_tab[i].res);

    // reset settings, no idling on either side
    random_traffic(PHASE_ITEMS);
    wait_drained();

    // one-byte limit, zero timeout, sender mostly idle
    set_regs(8'h00, 8'hFF, 16'd1, 16'hAB00, 32'd0);
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    random_traffic(PHASE_ITEMS);
    wait_drained();

    // widest limits, receiver mostly stalled, one full hold-off midway
    set_regs(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    random_traffic(PHASE_ITEMS / 2);
    wait_drained();
    random_traffic(PHASE_ITEMS / 2);
    wait_drained();

    // random settings, both sides idling, one frame at the length limit
    set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(20, 48)),
             16'($urandom), 32'($urandom_range(1, 12)));
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    send_frame(rx_cfg.max_frame_bytes, rx_cfg.ack_type, 1'b1);
    random_traffic(PHASE_ITEMS);
    wait_drained();

    // default symbols with a one-tick timeout
    set_regs(8'h02, 8'h03, 16'd256, 16'h0000, 32'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(PHASE_ITEMS);
    wait_drained();

    $display("run covered %0d input transfers and %0d checked results over five settings",
             n_items, n_checked);
    $display("types %0d, bytes %0d, frames done %0d, rejected %0d, ack timeouts %0d",
             kind_cnt[KIND_TYPE], kind_cnt[KIND_BYTE], kind_cnt[KIND_COMPLETE],
             kind_cnt[KIND_REJECT], kind_cnt[KIND_TIMEOUT]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
